### hdl/wfsm_pkg.sv
// Shared types and constants for the WLAN frame statistics monitor.
// Used by wfsm_div, wfsm_stats and wlan_frame_statistics_monitor_unit.
// No dependencies.
package wfsm_pkg;

   localparam int NUM_W   = 42;
   localparam int DEN_W   = 32;
   localparam int CNT_W32 = 32;

   localparam logic [1:0] MODE_FRAME = 2'd0;
   localparam logic [1:0] MODE_TICK  = 2'd1;
   localparam logic [1:0] MODE_CLEAR = 2'd2;

   localparam logic [2:0] KIND_MGMT = 3'd0;
   localparam logic [2:0] KIND_DATA = 3'd1;
   localparam logic [2:0] KIND_CTRL = 3'd2;
   localparam logic [2:0] KIND_MISC = 3'd3;

   localparam int FC_TO_DS   = 8;
   localparam int FC_FROM_DS = 9;

   localparam logic [3:0] SUB_PROBE_REQ  = 4'd4;
   localparam logic [3:0] SUB_PROBE_RESP = 4'd5;
   localparam logic [3:0] SUB_BEACON     = 4'd8;

   localparam logic [0:0] CSR_SAMPLE_PERIOD = 1'd0;
   localparam logic [0:0] CSR_RATE_CAP      = 1'd1;

   localparam logic [15:0] PERIOD_RESET   = 16'd150;
   localparam logic [15:0] RATE_CAP_RESET = 16'd20000;

   localparam logic [9:0] PPS_SCALE  = 10'd1000;
   localparam logic [9:0] KBPS_SCALE = 10'd80;

   typedef struct packed {
      logic             start;
      logic [NUM_W-1:0] num;
      logic [DEN_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [NUM_W-1:0] quot;
   } div_rsp_type;

   typedef struct packed {
      logic frame_en;
      logic clear_en;
      logic snap_en;
   } stats_ctl_type;

   typedef struct packed {
      logic [31:0] total;
      logic [31:0] mgmt;
      logic [31:0] beacon;
      logic [31:0] probe;
      logic [31:0] data;
      logic [31:0] ctrl;
      logic [31:0] misc;
      logic [31:0] rssi_accum;
      logic [31:0] rssi_samples;
      logic [31:0] d_total;
      logic [31:0] d_up;
      logic [31:0] d_down;
   } stats_type;

endpackage

### hdl/wfsm_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on wfsm_pkg for operand widths and request/response types.
module wfsm_div (
   input  logic                 clock,
   input  logic                 reset,
   input  wfsm_pkg::div_req_type div_req,
   output wfsm_pkg::div_rsp_type div_rsp
);
   import wfsm_pkg::*;

   localparam int CNT_W = $clog2(NUM_W);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W:0]   rem_sh;
   logic             ge;

   assign rem_sh = {rem_ff, quo_ff[NUM_W-1]};
   assign ge     = rem_sh >= {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(NUM_W - 1);
         rem_in  = '0;
         den_in  = div_req.den;
         quo_in  = div_req.num;
      end else if (busy_ff) begin
         rem_in = ge ? DEN_W'(rem_sh - {1'b0, den_ff}) : rem_sh[DEN_W-1:0];
         quo_in = {quo_ff[NUM_W-2:0], ge};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quot = quo_ff;

endmodule

### hdl/wfsm_stats.sv
// Frame counter bank: per-kind counts, RSSI sum, byte totals and tick snapshots.
// Depends on wfsm_pkg for field codes and the control and status structs.
module wfsm_stats (
   input  logic                   clock,
   input  logic                   reset,
   input  wfsm_pkg::stats_ctl_type stats_ctl,
   input  logic [2:0]             frame_kind,
   input  logic [15:0]            frame_control,
   input  logic                   has_payload,
   input  logic [15:0]            frame_length,
   input  logic signed [7:0]      rssi_dbm,
   output wfsm_pkg::stats_type     stats
);
   import wfsm_pkg::*;

   typedef struct packed {
      logic [31:0] total;
      logic [31:0] mgmt;
      logic [31:0] beacon;
      logic [31:0] probe;
      logic [31:0] data;
      logic [31:0] ctrl;
      logic [31:0] misc;
      logic [31:0] rssi_accum;
      logic [31:0] rssi_samples;
      logic [31:0] bytes_up;
      logic [31:0] bytes_down;
      logic [31:0] last_total;
      logic [31:0] last_up;
      logic [31:0] last_down;
   } counter_set_type;

   counter_set_type cnt_ff, cnt_in;
   logic            to_ds, from_ds, len_ok;
   logic [3:0]      subtype;

   assign to_ds   = frame_control[FC_TO_DS];
   assign from_ds = frame_control[FC_FROM_DS];
   assign subtype = frame_control[7:4];
   assign len_ok  = has_payload && (frame_length >= 16'd2);

   always_comb begin
      cnt_in = cnt_ff;
      if (stats_ctl.clear_en) begin
         cnt_in = '0;
      end else if (stats_ctl.frame_en) begin
         cnt_in.total        = cnt_ff.total + 32'd1;
         cnt_in.rssi_accum   = cnt_ff.rssi_accum + 32'(rssi_dbm);
         cnt_in.rssi_samples = cnt_ff.rssi_samples + 32'd1;
         if (len_ok && to_ds && !from_ds) begin
            cnt_in.bytes_up = cnt_ff.bytes_up + {16'd0, frame_length};
         end
         if (len_ok && !to_ds && from_ds) begin
            cnt_in.bytes_down = cnt_ff.bytes_down + {16'd0, frame_length};
         end
         unique case (frame_kind)
            KIND_MGMT: begin
               cnt_in.mgmt = cnt_ff.mgmt + 32'd1;
               if (has_payload && subtype == SUB_BEACON) begin
                  cnt_in.beacon = cnt_ff.beacon + 32'd1;
               end
               if (has_payload && (subtype == SUB_PROBE_REQ || subtype == SUB_PROBE_RESP)) begin
                  cnt_in.probe = cnt_ff.probe + 32'd1;
               end
            end
            KIND_DATA: cnt_in.data = cnt_ff.data + 32'd1;
            KIND_CTRL: cnt_in.ctrl = cnt_ff.ctrl + 32'd1;
            KIND_MISC: cnt_in.misc = cnt_ff.misc + 32'd1;
            default: ;
         endcase
      end else if (stats_ctl.snap_en) begin
         cnt_in.last_total = cnt_ff.total;
         cnt_in.last_up    = cnt_ff.bytes_up;
         cnt_in.last_down  = cnt_ff.bytes_down;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_comb begin
      stats.total        = cnt_ff.total;
      stats.mgmt         = cnt_ff.mgmt;
      stats.beacon       = cnt_ff.beacon;
      stats.probe        = cnt_ff.probe;
      stats.data         = cnt_ff.data;
      stats.ctrl         = cnt_ff.ctrl;
      stats.misc         = cnt_ff.misc;
      stats.rssi_accum   = cnt_ff.rssi_accum;
      stats.rssi_samples = cnt_ff.rssi_samples;
      stats.d_total = (cnt_ff.total >= cnt_ff.last_total) ?
                      cnt_ff.total - cnt_ff.last_total : 32'd0;
      stats.d_up    = (cnt_ff.bytes_up >= cnt_ff.last_up) ?
                      cnt_ff.bytes_up - cnt_ff.last_up : 32'd0;
      stats.d_down  = (cnt_ff.bytes_down >= cnt_ff.last_down) ?
                      cnt_ff.bytes_down - cnt_ff.last_down : 32'd0;
   end

endmodule

### hdl/wlan_frame_statistics_monitor_unit.sv
// WLAN frame statistics monitor top level: sequencer, config registers, result beat.
// Frame and clear beats may arrive every cycle while the sequencer is idle (req_stall low).
// A tick beat runs one snapshot state, then four
// 42-bit divisions (pps, uplink, downlink, RSSI average) in turn on the
// shared bit-serial divider, then loads the result register once rsp_stall allows it.
// Synchronous active-high reset clears all counters and restores period 150 and cap 20000.
module wlan_frame_statistics_monitor_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_mode,
   input  logic [2:0]         req_frame_kind,
   input  logic [15:0]        req_frame_control,
   input  logic               req_has_payload,
   input  logic [15:0]        req_frame_length,
   input  logic signed [7:0]  req_rssi_dbm,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [15:0]        rsp_rate_pps,
   output logic [31:0]        rsp_up_kbps_tenths,
   output logic [31:0]        rsp_down_kbps_tenths,
   output logic signed [7:0]  rsp_avg_rssi,
   output logic [31:0]        rsp_total_count,
   output logic [31:0]        rsp_mgmt_count,
   output logic [31:0]        rsp_beacon_count,
   output logic [31:0]        rsp_probe_count,
   output logic [31:0]        rsp_data_count,
   output logic [31:0]        rsp_ctrl_count,
   output logic [31:0]        rsp_misc_count,
   input  logic               csr_wr_en,
   input  logic [0:0]         csr_index,
   input  logic [15:0]        csr_wr_data
);
   import wfsm_pkg::*;

   typedef enum logic [2:0] {S_IDLE, S_SNAP, S_LOAD, S_WAIT, S_DONE} state_type;
   typedef enum logic [1:0] {OP_PPS, OP_UP, OP_DOWN, OP_RSSI} op_type;

   state_type     state_ff;
   op_type        op_ff;
   logic [15:0]   period_ff, cap_ff;
   logic [31:0]   dt_ff, du_ff, dd_ff, mag_ff;
   logic          neg_ff, has_smp_ff;
   logic [15:0]   pps_ff;
   logic [31:0]   up_ff, down_ff;
   logic [7:0]    avg_ff;
   logic          rsp_valid_ff;
   logic [15:0]   rsp_pps_ff;
   logic [31:0]   rsp_up_ff, rsp_down_ff;
   logic [7:0]    rsp_avg_ff;
   logic [31:0]   rsp_total_ff, rsp_mgmt_ff, rsp_beacon_ff, rsp_probe_ff;
   logic [31:0]   rsp_data_ff, rsp_ctrl_ff, rsp_misc_ff;

   logic          accept;
   stats_ctl_type stats_ctl;
   stats_type     stats;
   div_req_type   div_req;
   div_rsp_type   div_rsp;
   logic [15:0]   period_eff;
   logic [31:0]   q_sat;
   logic [7:0]    avg_val;

   assign req_stall  = state_ff != S_IDLE;
   assign accept     = req_valid && !req_stall;
   assign period_eff = (period_ff == 16'd0) ? 16'd1 : period_ff;

   assign stats_ctl.frame_en = accept && req_mode == MODE_FRAME;
   assign stats_ctl.clear_en = accept && req_mode == MODE_CLEAR;
   assign stats_ctl.snap_en  = state_ff == S_SNAP;

   wfsm_stats u_stats (
      .clock         (clock),
      .reset         (reset),
      .stats_ctl     (stats_ctl),
      .frame_kind    (req_frame_kind),
      .frame_control (req_frame_control),
      .has_payload   (req_has_payload),
      .frame_length  (req_frame_length),
      .rssi_dbm      (req_rssi_dbm),
      .stats         (stats)
   );

   always_comb begin
      div_req.start = state_ff == S_LOAD;
      div_req.den   = {16'd0, period_eff};
      unique case (op_ff)
         OP_PPS:  div_req.num = NUM_W'(dt_ff) * NUM_W'(PPS_SCALE);
         OP_UP:   div_req.num = NUM_W'(du_ff) * NUM_W'(KBPS_SCALE);
         OP_DOWN: div_req.num = NUM_W'(dd_ff) * NUM_W'(KBPS_SCALE);
         OP_RSSI: begin
            div_req.num = NUM_W'(mag_ff);
            div_req.den = stats.rssi_samples;
         end
      endcase
   end

   wfsm_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign q_sat = (div_rsp.quot[NUM_W-1:32] != '0) ? 32'hFFFF_FFFF : div_rsp.quot[31:0];

   always_comb begin
      if (!has_smp_ff) begin
         avg_val = 8'd0;
      end else if (neg_ff) begin
         avg_val = (div_rsp.quot > NUM_W'(128)) ? 8'h80 : 8'(-div_rsp.quot[7:0]);
      end else begin
         avg_val = (div_rsp.quot > NUM_W'(127)) ? 8'h7F : div_rsp.quot[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         op_ff        <= OP_PPS;
         rsp_valid_ff <= 1'b0;
         period_ff    <= PERIOD_RESET;
         cap_ff       <= RATE_CAP_RESET;
      end else begin
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_SAMPLE_PERIOD: period_ff <= csr_wr_data;
               CSR_RATE_CAP:      cap_ff    <= csr_wr_data;
            endcase
         end
         if (rsp_valid_ff && !rsp_stall && state_ff != S_DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (accept && req_mode == MODE_TICK) begin
                  state_ff <= S_SNAP;
               end
            end
            S_SNAP: begin
               dt_ff      <= stats.d_total;
               du_ff      <= stats.d_up;
               dd_ff      <= stats.d_down;
               neg_ff     <= stats.rssi_accum[31];
               mag_ff     <= stats.rssi_accum[31] ? 32'(-stats.rssi_accum) : stats.rssi_accum;
               has_smp_ff <= stats.rssi_samples != 32'd0;
               op_ff      <= OP_PPS;
               state_ff   <= S_LOAD;
            end
            S_LOAD: begin
               state_ff <= S_WAIT;
            end
            S_WAIT: begin
               if (div_rsp.done) begin
                  unique case (op_ff)
                     OP_PPS: begin
                        pps_ff   <= (div_rsp.quot > NUM_W'(cap_ff)) ? cap_ff
                                                                    : div_rsp.quot[15:0];
                        op_ff    <= OP_UP;
                        state_ff <= S_LOAD;
                     end
                     OP_UP: begin
                        up_ff    <= q_sat;
                        op_ff    <= OP_DOWN;
                        state_ff <= S_LOAD;
                     end
                     OP_DOWN: begin
                        down_ff  <= q_sat;
                        op_ff    <= OP_RSSI;
                        state_ff <= S_LOAD;
                     end
                     OP_RSSI: begin
                        avg_ff   <= avg_val;
                        state_ff <= S_DONE;
                     end
                  endcase
               end
            end
            S_DONE: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_pps_ff    <= pps_ff;
                  rsp_up_ff     <= up_ff;
                  rsp_down_ff   <= down_ff;
                  rsp_avg_ff    <= avg_ff;
                  rsp_total_ff  <= stats.total;
                  rsp_mgmt_ff   <= stats.mgmt;
                  rsp_beacon_ff <= stats.beacon;
                  rsp_probe_ff  <= stats.probe;
                  rsp_data_ff   <= stats.data;
                  rsp_ctrl_ff   <= stats.ctrl;
                  rsp_misc_ff   <= stats.misc;
                  state_ff      <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_rate_pps         = rsp_pps_ff;
   assign rsp_up_kbps_tenths   = rsp_up_ff;
   assign rsp_down_kbps_tenths = rsp_down_ff;
   assign rsp_avg_rssi         = rsp_avg_ff;
   assign rsp_total_count      = rsp_total_ff;
   assign rsp_mgmt_count       = rsp_mgmt_ff;
   assign rsp_beacon_count     = rsp_beacon_ff;
   assign rsp_probe_count      = rsp_probe_ff;
   assign rsp_data_count       = rsp_data_ff;
   assign rsp_ctrl_count       = rsp_ctrl_ff;
   assign rsp_misc_count       = rsp_misc_ff;

endmodule
